// ===== design/sor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sor_pkg
// Shared types and constants of the spike outlier rejector.
// ---------------------------------------------------------------------------
package sor_pkg;

  localparam int CALIB_POINTS = 5;
  localparam int IDX_W        = $clog2(CALIB_POINTS);
  localparam int CNT_W        = $clog2(CALIB_POINTS + 1);
  localparam int SUM_W        = 32 + CNT_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [7:0]         THR_MULT_RST  = 8'd12;
  localparam logic [15:0]        MATCH_TOL_RST = 16'd655;
  localparam logic signed [31:0] NO_MATCH_RST  = -32'sd65536000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_MULT,
    REG_MATCH_TOL,
    REG_NO_MATCH
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAL_INIT,
    OP_SUM_ACC,
    OP_DIV_MEAN,
    OP_MEAN_SET,
    OP_VAR_DIFF,
    OP_VAR_SQ,
    OP_DIV_VAR,
    OP_VAR_ACC,
    OP_SQRT,
    OP_THR,
    OP_ADVANCE,
    OP_NEXT,
    OP_LOAD_NEW,
    OP_SHIFT,
    OP_KEEP_FIRST,
    OP_TEST1,
    OP_EXPECT,
    OP_INT_MUL,
    OP_DIV_INT,
    OP_INT_SET,
    OP_TEST2,
    OP_EMIT,
    OP_END
  } op_t;

  typedef struct packed {
    logic mode_cal;
    logic full;
    logic fin;
    logic last_i;
    logic div_done;
    logic sqrt_done;
    logic first;
    logic has_next;
    logic final_item;
    logic keep;
    logic interp;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] x_error;
    logic signed [31:0] y_error;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_x_error;
    logic signed [31:0] out_y_error;
    logic               kept;
    logic               last_result;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/sor_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sor_if
// Point input and decision output channels, valid/ready.
// ---------------------------------------------------------------------------
interface sor_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] x_error;
  logic signed [31:0] y_error;
  logic               last_sample;

  modport source (output valid, sample_x, sample_y, x_error, y_error, last_sample,
                  input ready);
  modport sink (input valid, sample_x, sample_y, x_error, y_error, last_sample,
                output ready);
endinterface

interface sor_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_x_error;
  logic signed [31:0] out_y_error;
  logic               kept;
  logic               last_result;

  modport source (output valid, out_x, out_y, out_x_error, out_y_error, kept,
                  last_result, input ready);
  modport sink (input valid, out_x, out_y, out_x_error, out_y_error, kept,
                last_result, output ready);
endinterface
`default_nettype wire

// ===== design/sor_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sor_div
// Restoring unsigned divider, 64 by 32 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sor_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [31:0]      remainder
);

  logic [63:0] q;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem, q[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      q    <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sub[31:0];
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient  = q;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== design/sor_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sor_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// ---------------------------------------------------------------------------
module sor_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] v;
  logic [32:0] rem;
  logic [31:0] rt;
  logic [4:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [34:0] rem_sub;

  assign rem_sh  = {rem, v[63:62]};
  assign trial   = {1'b0, rt, 2'b01};
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      v    <= radicand;
      rem  <= '0;
      rt   <= '0;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (rem_sh >= trial) begin
        rem <= rem_sub[32:0];
        rt  <= {rt[30:0], 1'b1};
      end else begin
        rem <= rem_sh[32:0];
        rt  <= {rt[30:0], 1'b0};
      end
      v   <= {v[61:0], 2'b00};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = rt;

endmodule
`default_nettype wire

// ===== design/sor_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sor_ctrl
// Sequencer: calibration, per-point judgement and emission of decisions.
// ---------------------------------------------------------------------------
module sor_ctrl import sor_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_fire,
  input  wire status_t status,
  output logic         in_ready,
  output op_t          op
);

  typedef enum logic [4:0] {
    S_IDLE, S_CAPT, S_SUM, S_MEAN, S_MEANW, S_VD, S_VSQ, S_VDIV, S_VW,
    S_SQ, S_SQW, S_ADV1, S_ADV2, S_JUDGE, S_T1, S_EXP, S_IDIV, S_IW,
    S_T2, S_EMIT, S_NEXT, S_SHF, S_END
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_next = S_CAPT;
      end
      S_CAPT: begin
        if (status.mode_cal) begin
          if (!status.fin && !status.full) begin
            state_next = S_IDLE;
          end else begin
            op         = OP_CAL_INIT;
            state_next = S_SUM;
          end
        end else begin
          op         = OP_LOAD_NEW;
          state_next = S_JUDGE;
        end
      end
      S_SUM: begin
        op = OP_SUM_ACC;
        if (status.last_i) state_next = S_MEAN;
      end
      S_MEAN: begin
        op         = OP_DIV_MEAN;
        state_next = S_MEANW;
      end
      S_MEANW: begin
        if (status.div_done) begin
          op         = OP_MEAN_SET;
          state_next = S_VD;
        end
      end
      S_VD: begin
        op         = OP_VAR_DIFF;
        state_next = S_VSQ;
      end
      S_VSQ: begin
        op         = OP_VAR_SQ;
        state_next = S_VDIV;
      end
      S_VDIV: begin
        op         = OP_DIV_VAR;
        state_next = S_VW;
      end
      S_VW: begin
        if (status.div_done) begin
          op         = OP_VAR_ACC;
          state_next = status.last_i ? S_SQ : S_VD;
        end
      end
      S_SQ: begin
        op         = OP_SQRT;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (status.sqrt_done) begin
          op         = OP_THR;
          state_next = S_ADV1;
        end
      end
      S_ADV1: begin
        op         = OP_ADVANCE;
        state_next = S_ADV2;
      end
      S_ADV2: begin
        op         = OP_ADVANCE;
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        if (status.mode_cal && !status.fin && status.final_item) begin
          state_next = S_IDLE;
        end else if (status.first) begin
          op         = OP_KEEP_FIRST;
          state_next = S_EMIT;
        end else begin
          op         = OP_TEST1;
          state_next = S_T1;
        end
      end
      S_T1: begin
        if (status.keep || !status.has_next) begin
          state_next = S_EMIT;
        end else begin
          op         = OP_EXPECT;
          state_next = S_EXP;
        end
      end
      S_EXP: begin
        if (status.interp) begin
          op         = OP_INT_MUL;
          state_next = S_IDIV;
        end else begin
          state_next = S_T2;
        end
      end
      S_IDIV: begin
        op         = OP_DIV_INT;
        state_next = S_IW;
      end
      S_IW: begin
        if (status.div_done) begin
          op         = OP_INT_SET;
          state_next = S_T2;
        end
      end
      S_T2: begin
        op         = OP_TEST2;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          op = OP_EMIT;
          if (status.final_item) state_next = S_END;
          else if (status.mode_cal) state_next = S_NEXT;
          else state_next = S_SHF;
        end
      end
      S_NEXT: begin
        op         = OP_NEXT;
        state_next = S_JUDGE;
      end
      S_SHF: begin
        op         = OP_SHIFT;
        state_next = status.fin ? S_JUDGE : S_IDLE;
      end
      S_END: begin
        op         = OP_END;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/sor_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sor_dp
// Datapath: calibration buffer, statistics, judgement window, result register.
// ---------------------------------------------------------------------------
module sor_dp import sor_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_fire,
  input  wire in_item_t              in_item,
  input  wire logic                  out_fire,
  input  wire op_t                   op,
  output status_t                    status,
  output out_item_t                  out_item,
  output logic                       out_valid
);

  logic [7:0]         thr_mult;
  logic [15:0]        match_tol;
  logic signed [31:0] no_match;

  logic signed [31:0] mem_x  [CALIB_POINTS];
  logic signed [31:0] mem_y  [CALIB_POINTS];
  logic signed [31:0] mem_xe [CALIB_POINTS];
  logic signed [31:0] mem_ye [CALIB_POINTS];

  logic [CNT_W-1:0]   ps;
  logic               mode_cal;
  in_item_t           in_reg;
  logic [CNT_W-1:0]   cidx;
  logic [CNT_W-1:0]   dec_i;
  logic               stage2;

  logic signed [SUM_W-1:0] sum;
  logic signed [31:0] mean;
  logic [31:0]        dmag;
  logic [63:0]        dsq;
  logic [63:0]        var_acc;
  logic [31:0]        thr;
  logic signed [31:0] lky;

  logic signed [31:0] pv_x, pv_y, cu_x, cu_y, cu_xe, cu_ye;
  logic signed [31:0] nx_x, nx_y, nx_xe, nx_ye;
  logic               keep;
  logic               interp;
  logic               ineg;
  logic signed [31:0] expv;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;

  logic [IDX_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   dec_inc;
  logic [SUM_W-1:0]   sum_mag;
  logic [33:0]        vd, d1, d2, dm, sp, fx, dy, e_up, e_dn;
  logic [33:0]        vd_m, d1_m, d2_m, dm_m, dy_m;
  logic [64:0]        var_sum;
  logic [39:0]        thr_prod;
  logic               div_start, div_done, sqrt_done;
  logic [63:0]        div_dividend, div_q;
  logic [31:0]        div_divisor, div_r, root;

  function automatic logic [33:0] ext(input logic signed [31:0] v);
    ext = {{2{v[31]}}, v};
  endfunction

  function automatic logic [33:0] mag(input logic [33:0] v);
    mag = v[33] ? (34'd0 - v) : v;
  endfunction

  assign rd_idx  = (cidx < CNT_W'(CALIB_POINTS)) ? cidx[IDX_W-1:0] : '0;
  assign dec_inc = dec_i + CNT_W'(1);
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign vd   = ext(mem_y[rd_idx]) - ext(mean);
  assign vd_m = mag(vd);
  assign d1   = ext(cu_y) - ext(lky);
  assign d1_m = mag(d1);
  assign d2   = ext(cu_y) - ext(expv);
  assign d2_m = mag(d2);
  assign dm   = ext(nx_x) - ext(cu_x);
  assign dm_m = mag(dm);
  assign sp   = ext(nx_x) - ext(pv_x);
  assign fx   = ext(cu_x) - ext(pv_x);
  assign dy   = ext(nx_y) - ext(pv_y);
  assign dy_m = mag(dy);
  assign e_up = ext(pv_y) + {2'b00, div_q[31:0]};
  assign e_dn = ext(pv_y) - {2'b00, div_q[31:0]};

  assign var_sum  = {1'b0, var_acc} + {1'b0, div_q};
  assign thr_prod = thr_mult * root;

  assign div_start = (op == OP_DIV_MEAN) || (op == OP_DIV_VAR) || (op == OP_DIV_INT);

  always_comb begin
    case (op)
      OP_DIV_MEAN: begin
        div_dividend = 64'(sum_mag);
        div_divisor  = 32'(ps);
      end
      OP_DIV_VAR: begin
        div_dividend = dsq;
        div_divisor  = 32'(ps);
      end
      default: begin
        div_dividend = prod;
        div_divisor  = sp[31:0];
      end
    endcase
  end

  sor_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  sor_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (op == OP_SQRT),
    .radicand (var_acc),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_mult  <= THR_MULT_RST;
      match_tol <= MATCH_TOL_RST;
      no_match  <= NO_MATCH_RST;
      ps        <= '0;
      mode_cal  <= 1'b1;
      stage2    <= 1'b0;
      thr       <= '0;
      lky       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THR_MULT:  thr_mult  <= cfg_data[7:0];
          REG_MATCH_TOL: match_tol <= cfg_data[15:0];
          REG_NO_MATCH:  no_match  <= cfg_data;
          default: ;
        endcase
      end

      if (out_fire) out_valid <= 1'b0;

      if (in_fire) begin
        in_reg <= in_item;
        if (ps < CNT_W'(CALIB_POINTS)) begin
          mem_x[ps[IDX_W-1:0]]  <= in_item.sample_x;
          mem_y[ps[IDX_W-1:0]]  <= in_item.sample_y;
          mem_xe[ps[IDX_W-1:0]] <= in_item.x_error;
          mem_ye[ps[IDX_W-1:0]] <= in_item.y_error;
          ps       <= ps + CNT_W'(1);
          mode_cal <= 1'b1;
        end else begin
          mode_cal <= 1'b0;
        end
      end

      case (op)
        OP_CAL_INIT: begin
          sum  <= '0;
          cidx <= '0;
        end
        OP_SUM_ACC: begin
          sum  <= sum + SUM_W'(mem_y[rd_idx]);
          cidx <= cidx + CNT_W'(1);
        end
        OP_MEAN_SET: begin
          if (sum[SUM_W-1]) begin
            mean <= (div_r != '0) ? ~div_q[31:0] : ~div_q[31:0] + 32'd1;
          end else begin
            mean <= div_q[31:0];
          end
          cidx    <= '0;
          var_acc <= '0;
        end
        OP_VAR_DIFF: dmag <= vd_m[31:0];
        OP_VAR_SQ:   dsq  <= dmag * dmag;
        OP_VAR_ACC: begin
          var_acc <= var_sum[64] ? '1 : var_sum[63:0];
          cidx    <= cidx + CNT_W'(1);
        end
        OP_THR: begin
          thr   <= (thr_prod[39:32] != '0) ? '1 : thr_prod[31:0];
          cidx  <= '0;
          dec_i <= '0;
        end
        OP_ADVANCE, OP_NEXT: begin
          pv_x  <= cu_x;
          pv_y  <= cu_y;
          cu_x  <= nx_x;
          cu_y  <= nx_y;
          cu_xe <= nx_xe;
          cu_ye <= nx_ye;
          nx_x  <= mem_x[rd_idx];
          nx_y  <= mem_y[rd_idx];
          nx_xe <= mem_xe[rd_idx];
          nx_ye <= mem_ye[rd_idx];
          cidx  <= cidx + CNT_W'(1);
          if (op == OP_NEXT) dec_i <= dec_inc;
        end
        OP_LOAD_NEW: begin
          nx_x   <= in_reg.sample_x;
          nx_y   <= in_reg.sample_y;
          nx_xe  <= in_reg.x_error;
          nx_ye  <= in_reg.y_error;
          stage2 <= 1'b0;
        end
        OP_SHIFT: begin
          pv_x   <= cu_x;
          pv_y   <= cu_y;
          cu_x   <= nx_x;
          cu_y   <= nx_y;
          cu_xe  <= nx_xe;
          cu_ye  <= nx_ye;
          stage2 <= 1'b1;
        end
        OP_KEEP_FIRST: begin
          keep <= 1'b1;
          lky  <= cu_y;
        end
        OP_TEST1: begin
          keep <= d1_m[32:0] < {1'b0, thr};
          if (d1_m[32:0] < {1'b0, thr}) lky <= cu_y;
        end
        OP_EXPECT: begin
          interp <= 1'b0;
          mul_a  <= fx[31:0];
          mul_b  <= dy_m[31:0];
          ineg   <= nx_y < pv_y;
          if (dm_m[32:0] <= 33'(match_tol)) begin
            expv <= nx_y;
          end else if (pv_x <= cu_x && cu_x <= nx_x) begin
            if (sp[33] || sp == '0) expv <= nx_y;
            else interp <= 1'b1;
          end else begin
            expv <= no_match;
          end
        end
        OP_INT_MUL: prod <= mul_a * mul_b;
        OP_INT_SET: expv <= ineg ? e_dn[31:0] : e_up[31:0];
        OP_TEST2: begin
          keep <= d2_m[32:0] < {1'b0, thr};
          if (d2_m[32:0] < {1'b0, thr}) lky <= cu_y;
        end
        OP_EMIT: begin
          out_item.out_x       <= cu_x;
          out_item.out_y       <= cu_y;
          out_item.out_x_error <= cu_xe;
          out_item.out_y_error <= cu_ye;
          out_item.kept        <= keep;
          out_item.last_result <= in_reg.last_sample && status.final_item;
          out_valid            <= 1'b1;
        end
        OP_END: begin
          ps  <= '0;
          thr <= '0;
          lky <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.mode_cal   = mode_cal;
    status.full       = ps == CNT_W'(CALIB_POINTS);
    status.fin        = in_reg.last_sample;
    status.last_i     = cidx == (ps - CNT_W'(1));
    status.div_done   = div_done;
    status.sqrt_done  = sqrt_done;
    status.first      = mode_cal && (dec_i == '0);
    status.has_next   = mode_cal ? (dec_inc < ps) : !stage2;
    status.final_item = mode_cal ? (dec_inc == ps) : stage2;
    status.keep       = keep;
    status.interp     = interp;
    status.out_free   = !out_valid;
  end

endmodule
`default_nettype wire

// ===== design/spike_outlier_rejector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spike_outlier_rejector
// Spike rejection on a stream of Q16.16 points, decided one point late.
// ---------------------------------------------------------------------------
// The first CALIB_POINTS points of a series are buffered; when the buffer
// fills (or last_sample arrives early) the block computes mean, variance and
// RMS, then emits the buffered decisions one by one. The statistics run on
// the bit-serial 64-bit divider and the 32-step square root. A buffered
// decision needs the second test only when the first fails, and the divider
// only when it interpolates; the same holds for each later point. The final
// point adds one more decision. Results sit in an output register, and a
// stalled receiver holds the block until the register is taken; input is
// taken again once the current point is done.
module spike_outlier_rejector import sor_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  sor_in_if.sink                     in_ch,
  sor_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic      in_ready;
  logic      in_fire;
  logic      out_fire;
  logic      out_valid;
  op_t       op;
  status_t   status;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign out_fire    = out_valid && out_ch.ready;

  assign in_item.sample_x    = in_ch.sample_x;
  assign in_item.sample_y    = in_ch.sample_y;
  assign in_item.x_error     = in_ch.x_error;
  assign in_item.y_error     = in_ch.y_error;
  assign in_item.last_sample = in_ch.last_sample;

  assign out_ch.valid       = out_valid;
  assign out_ch.out_x       = out_item.out_x;
  assign out_ch.out_y       = out_item.out_y;
  assign out_ch.out_x_error = out_item.out_x_error;
  assign out_ch.out_y_error = out_item.out_y_error;
  assign out_ch.kept        = out_item.kept;
  assign out_ch.last_result = out_item.last_result;

  sor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  sor_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .out_fire  (out_fire),
    .op        (op),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule
`default_nettype wire
